@@ hw/rtl/pidaw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and constants for the anti-windup PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       limited;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_KP       = 3'd1,
    REG_KI_T     = 3'd2,
    REG_KD_T     = 3'd3,
    REG_OUT_MAX  = 3'd4,
    REG_OUT_MIN  = 3'd5,
    REG_INT_MAX  = 3'd6,
    REG_INT_MIN  = 3'd7
  } cfg_reg_t;

  // Input op codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P,
    ST_I,
    ST_D,
    ST_AW,
    ST_FILT,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_MUL_P,
    DP_MUL_I,
    DP_MUL_D,
    DP_AW,
    DP_FILT,
    DP_SUM,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  localparam logic signed [51:0] S32_MAX = 52'sd2147483647;
  localparam logic signed [51:0] S32_MIN = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < S32_MIN) begin
      r = -32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pid_controller_antiwindup.sv @@
`timescale 1ns / 1ps
// An update sample's result is registered when the output step issues it, after the
// P, I, D, AW, FILT and SUM steps. A new update sample is taken only in idle; the five
// products share a single multiplier. A clear beat is taken in idle, with no sequence.
// The input is taken while a finished result still waits on a stalled output.
// Reset (rst_n, synchronous, active low) restores register defaults and zeroes state.
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID with integral clamp, back-calculation anti-windup and a
// first-order filtered derivative on the measurement.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup #(
  parameter int DERIV_FILTER = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pidaw_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pidaw_pkg::out_item_t             out_data,
  input  logic                             cfg_wr_en,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidaw_pkg::CFG_W-1:0]      cfg_data
);
  import pidaw_pkg::*;

  ctrl_cmd_t cmd;

  pidaw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pidaw_datapath #(
    .DERIV_FILTER (DERIV_FILTER)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/pidaw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer: walks one sample through the shared-multiplier datapath and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pidaw_pkg::ctrl_cmd_t  cmd
);
  import pidaw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   out_free;
  logic   emit;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == ST_OUT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_op == OP_UPDATE)) state_nxt = ST_P;
      end
      ST_P:    state_nxt = ST_I;
      ST_I:    state_nxt = ST_D;
      ST_D:    state_nxt = ST_AW;
      ST_AW:   state_nxt = ST_FILT;
      ST_FILT: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    out_valid_nxt = emit || (out_valid_r && out_stall);
    cmd.op        = DP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) cmd.op = (in_op == OP_CLEAR) ? DP_CLEAR : DP_LOAD;
      end
      ST_P:    cmd.op = DP_MUL_P;
      ST_I:    cmd.op = DP_MUL_I;
      ST_D:    cmd.op = DP_MUL_D;
      ST_AW:   cmd.op = DP_AW;
      ST_FILT: cmd.op = DP_FILT;
      ST_SUM:  cmd.op = DP_SUM;
      ST_OUT: begin
        if (out_free) cmd.op = DP_OUT;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_update_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_UPDATE)) |=> (state_r == ST_P))
    else $error("update beat did not start the sequence");

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_CLEAR)) |=> (state_r == ST_IDLE))
    else $error("clear beat left idle");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> (cmd.op != DP_OUT))
    else $error("pending result overwritten");

endmodule

@@ hw/rtl/pidaw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_datapath
// Config registers, controller state and the PID arithmetic around one
// shared 32x17 signed multiplier.
// ----------------------------------------------------------------------------
module pidaw_datapath #(
  parameter int DERIV_FILTER = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pidaw_pkg::ctrl_cmd_t                 cmd,
  input  pidaw_pkg::in_item_t                  in_data,
  input  logic                                 cfg_wr_en,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidaw_pkg::CFG_W-1:0]          cfg_data,
  output pidaw_pkg::out_item_t                 out_data
);
  import pidaw_pkg::*;

  localparam logic signed [16:0] FILT_A = 17'(32768 - DERIV_FILTER);
  localparam logic signed [16:0] FILT_B = 17'(DERIV_FILTER);
  localparam logic signed [51:0] HALF_Q16 = 52'sd32768;

  // configuration
  logic signed [15:0] setpoint_r, out_max_r, out_min_r, int_max_r, int_min_r;
  logic signed [31:0] kp_r, ki_t_r, kd_t_r;

  // controller state
  logic signed [31:0] acc_r, filt_r;
  logic signed [15:0] last_r;

  // per-sample work registers
  logic signed [15:0] meas_r;
  logic signed [16:0] err_r, dm_r;
  logic signed [48:0] p_r, fa_r;
  logic signed [49:0] i_r, fsum_r;
  logic signed [31:0] raw_r, ic_r, d_r;
  logic signed [51:0] pi_r;
  out_item_t          out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;

  always_comb begin
    mul_a = kp_r;
    mul_b = err_r;
    case (cmd.op)
      DP_MUL_I: begin
        mul_a = ki_t_r;
        mul_b = err_r;
      end
      DP_MUL_D: begin
        mul_a = kd_t_r;
        mul_b = dm_r;
      end
      DP_AW: begin
        mul_a = raw_r;
        mul_b = FILT_A;
      end
      DP_FILT: begin
        mul_a = filt_r;
        mul_b = FILT_B;
      end
      default: begin
        mul_a = kp_r;
        mul_b = err_r;
      end
    endcase
  end

  assign mul_p = 49'(mul_a) * 49'(mul_b);

  // integral clamp
  logic signed [49:0] imax_q, imin_q, i_int;
  assign imax_q = 50'($signed({int_max_r, 16'h0000}));
  assign imin_q = 50'($signed({int_min_r, 16'h0000}));
  always_comb begin
    if (i_r > imax_q) begin
      i_int = imax_q;
    end else if (i_r < imin_q) begin
      i_int = imin_q;
    end else begin
      i_int = i_r;
    end
  end

  // raw derivative on the measurement, negated
  logic signed [51:0] raw_neg;
  assign raw_neg = 52'(-(50'(mul_p)));

  // back-calculation anti-windup
  logic signed [50:0] omax_q, omin_q, pi_sum, i_hi, i_lo, i_aw;
  assign omax_q = 51'($signed({out_max_r, 16'h0000}));
  assign omin_q = 51'($signed({out_min_r, 16'h0000}));
  assign pi_sum = 51'(p_r) + 51'(i_r);
  assign i_hi   = omax_q - 51'(p_r);
  assign i_lo   = omin_q - 51'(p_r);
  always_comb begin
    if (pi_sum > omax_q) begin
      i_aw = i_hi;
    end else if (pi_sum < omin_q) begin
      i_aw = i_lo;
    end else begin
      i_aw = 51'(i_r);
    end
  end

  // output rounding and clamp
  logic signed [51:0] y_sum;
  logic signed [35:0] y_full;
  logic signed [35:0] omax_y, omin_y;
  assign y_sum  = pi_r + 52'(d_r);
  assign y_full = y_sum[51:16];
  assign omax_y = 36'(out_max_r);
  assign omin_y = 36'(out_min_r);
  always_comb begin
    if (y_full > omax_y) begin
      out_data_nxt.drive   = out_max_r;
      out_data_nxt.limited = 1'b1;
    end else if (y_full < omin_y) begin
      out_data_nxt.drive   = out_min_r;
      out_data_nxt.limited = 1'b1;
    end else begin
      out_data_nxt.drive   = y_full[15:0];
      out_data_nxt.limited = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      kp_r       <= '0;
      ki_t_r     <= '0;
      kd_t_r     <= '0;
      out_max_r  <= 16'sh7fff;
      out_min_r  <= -16'sh8000;
      int_max_r  <= 16'sh7fff;
      int_min_r  <= -16'sh8000;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETPOINT: setpoint_r <= cfg_data[15:0];
        REG_KP:       kp_r       <= cfg_data;
        REG_KI_T:     ki_t_r     <= cfg_data;
        REG_KD_T:     kd_t_r     <= cfg_data;
        REG_OUT_MAX:  out_max_r  <= cfg_data[15:0];
        REG_OUT_MIN:  out_min_r  <= cfg_data[15:0];
        REG_INT_MAX:  int_max_r  <= cfg_data[15:0];
        REG_INT_MIN:  int_min_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // controller state, zeroed by a clear beat and committed when the result is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      last_r <= '0;
      filt_r <= '0;
    end else if (cmd.op == DP_CLEAR) begin
      acc_r  <= '0;
      last_r <= '0;
      filt_r <= '0;
    end else if (cmd.op == DP_OUT) begin
      acc_r  <= ic_r;
      last_r <= meas_r;
      filt_r <= d_r;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        meas_r <= in_data.measurement;
        err_r  <= 17'(setpoint_r) - 17'(in_data.measurement);
        dm_r   <= 17'(in_data.measurement) - 17'(last_r);
      end
      DP_MUL_P: p_r <= mul_p;
      DP_MUL_I: i_r <= 50'(acc_r) + 50'(mul_p);
      DP_MUL_D: begin
        raw_r <= sat32(raw_neg);
        i_r   <= i_int;
      end
      DP_AW: begin
        ic_r <= sat32(52'(i_aw));
        fa_r <= mul_p;
      end
      DP_FILT: fsum_r <= 50'(fa_r) + 50'(mul_p);
      DP_SUM: begin
        d_r  <= sat32(52'(fsum_r >>> 15));
        pi_r <= 52'(p_r) + 52'(ic_r) + HALF_Q16;
      end
      DP_OUT: out_data_r <= out_data_nxt;
      default: ;
    endcase
  end

  assign out_data = out_data_r;

endmodule
